>>> hdl/tldc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tldc_pkg;

  // cache geometry
  localparam int L1_ENTRIES = 32;
  localparam int L2_ENTRIES = 256;
  localparam int ADDR_WIDTH = 16;

  localparam int L1_IDX_W = $clog2(L1_ENTRIES);
  localparam int L2_IDX_W = $clog2(L2_ENTRIES);
  localparam int L1_TAG_W = ADDR_WIDTH - L1_IDX_W;
  localparam int L2_TAG_W = ADDR_WIDTH - L2_IDX_W;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int LAT_W      = 8;
  localparam int TOTAL_LAT_W = LAT_W + 1;
  localparam int CNT_W      = 32;

  localparam logic [LAT_W-1:0] L1_LATENCY_RESET = 8'd1;
  localparam logic [LAT_W-1:0] L2_LATENCY_RESET = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L1_LATENCY = 8'd0,
    REG_L2_LATENCY = 8'd1
  } cfg_reg_t;

  // level that served the access
  typedef enum logic [1:0] {
    LVL_L1   = 2'd0,
    LVL_L2   = 2'd1,
    LVL_MISS = 2'd2
  } hit_level_t;

  // outcome of one lookup, drives the statistics counters
  typedef struct packed {
    logic valid;
    logic l1_hit;
    logic l2_hit;
  } lookup_evt_t;

endpackage
`default_nettype wire

>>> hdl/tldc_tag_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tldc_tag_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/tldc_stats.sv
`timescale 1ns / 1ps
`default_nettype none
module tldc_stats (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tldc_pkg::lookup_evt_t     evt,
  output logic      [tldc_pkg::CNT_W-1:0] l1_hits,
  output logic      [tldc_pkg::CNT_W-1:0] l1_miss_cnt,
  output logic      [tldc_pkg::CNT_W-1:0] l2_hits,
  output logic      [tldc_pkg::CNT_W-1:0] l2_miss_cnt
);
  import tldc_pkg::*;

  logic [CNT_W-1:0] l1_hits_r, l1_miss_cnt_r, l2_hits_r, l2_miss_cnt_r;

  // wrapping event counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_hits_r     <= '0;
      l1_miss_cnt_r <= '0;
      l2_hits_r     <= '0;
      l2_miss_cnt_r <= '0;
    end else if (evt.valid) begin
      if (evt.l1_hit) begin
        l1_hits_r <= l1_hits_r + 1'b1;
      end else begin
        l1_miss_cnt_r <= l1_miss_cnt_r + 1'b1;
        if (evt.l2_hit) begin
          l2_hits_r <= l2_hits_r + 1'b1;
        end else begin
          l2_miss_cnt_r <= l2_miss_cnt_r + 1'b1;
        end
      end
    end
  end

  assign l1_hits     = l1_hits_r;
  assign l1_miss_cnt = l1_miss_cnt_r;
  assign l2_hits     = l2_hits_r;
  assign l2_miss_cnt = l2_miss_cnt_r;

endmodule
`default_nettype wire

>>> hdl/two_level_direct_mapped_cache_model_top.sv
`timescale 1ns / 1ps
`default_nettype none
// two-level direct-mapped cache timing model
// input: pulse start with in_address while busy is low; that beat is taken
//   at the clock edge. busy then stays high for one cycle.
// result: out_strobe rises at the edge that ends the busy cycle and is
//   high for exactly one cycle with out_latency, out_hit_level and the four
//   running hit/miss counters (values after this access); the beat is taken
//   at the edge that ends the strobe cycle. the receiver cannot stall.
// a new access is not taken while busy is high. the accepting edge reads
//   both tag memories (registered synchronous read); the busy cycle compares,
//   writes the tags back on a miss and registers the result. a new access may
//   be started in the cycle out_strobe is high; its reads see the previous write.
// configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   index 0 = l1_latency, index 1 = l2_latency, low 8 bits of cfg_data kept,
//   other indexes ignored. write only while no access is in flight.
// reset (rst_n low, synchronous): all valid bits and counters cleared,
//   latencies back to 1 and 10, no access in flight. no clearing pass is
//   needed; the block takes start in the first cycle after reset.
module two_level_direct_mapped_cache_model_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [tldc_pkg::ADDR_WIDTH-1:0]  in_address,
  output logic                                  out_strobe,
  output logic      [tldc_pkg::TOTAL_LAT_W-1:0] out_latency,
  output logic      [1:0]                       out_hit_level,
  output logic      [tldc_pkg::CNT_W-1:0]       out_first_level_hits,
  output logic      [tldc_pkg::CNT_W-1:0]       out_first_level_misses,
  output logic      [tldc_pkg::CNT_W-1:0]       out_second_level_hits,
  output logic      [tldc_pkg::CNT_W-1:0]       out_second_level_misses,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tldc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tldc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tldc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t                  state_r;
  logic [ADDR_WIDTH-1:0]   addr_r;
  logic                    out_strobe_r;
  logic [TOTAL_LAT_W-1:0]  out_latency_r;
  hit_level_t              out_hit_level_r;
  logic [LAT_W-1:0]        l1_lat_r, l2_lat_r;
  logic [L1_ENTRIES-1:0]   l1_valid_r;
  logic [L2_ENTRIES-1:0]   l2_valid_r;

  logic                    accept;
  logic [L1_IDX_W-1:0]     in_i1, i1;
  logic [L2_IDX_W-1:0]     in_i2, i2;
  logic [L1_TAG_W-1:0]     t1, l1_rdata;
  logic [L2_TAG_W-1:0]     t2, l2_rdata;
  logic                    l1_hit, l2_hit;
  logic                    l1_we, l2_we;
  lookup_evt_t             evt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_LOOKUP);

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_lat_r <= L1_LATENCY_RESET;
      l2_lat_r <= L2_LATENCY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_L1_LATENCY) begin
        l1_lat_r <= cfg_data[LAT_W-1:0];
      end else if (cfg_index == REG_L2_LATENCY) begin
        l2_lat_r <= cfg_data[LAT_W-1:0];
      end
    end
  end

  // address split: read side from the incoming beat, compare side from addr_r
  assign in_i1 = in_address[L1_IDX_W-1:0];
  assign in_i2 = in_address[L2_IDX_W-1:0];
  assign i1    = addr_r[L1_IDX_W-1:0];
  assign i2    = addr_r[L2_IDX_W-1:0];
  assign t1    = addr_r[ADDR_WIDTH-1:L1_IDX_W];
  assign t2    = addr_r[ADDR_WIDTH-1:L2_IDX_W];

  // tag memories
  tldc_tag_ram #(.DEPTH(L1_ENTRIES), .WIDTH(L1_TAG_W)) u_l1_tags (
    .clk   (clk),
    .we    (l1_we),
    .waddr (i1),
    .wdata (t1),
    .raddr (in_i1),
    .rdata (l1_rdata)
  );

  tldc_tag_ram #(.DEPTH(L2_ENTRIES), .WIDTH(L2_TAG_W)) u_l2_tags (
    .clk   (clk),
    .we    (l2_we),
    .waddr (i2),
    .wdata (t2),
    .raddr (in_i2),
    .rdata (l2_rdata)
  );

  // hit detect and fill decision
  always_comb begin
    l1_hit    = l1_valid_r[i1] && (l1_rdata == t1);
    l2_hit    = l2_valid_r[i2] && (l2_rdata == t2);
    l1_we     = (state_r == ST_LOOKUP) && !l1_hit;
    l2_we     = l1_we && !l2_hit;
    evt.valid  = (state_r == ST_LOOKUP);
    evt.l1_hit = l1_hit;
    evt.l2_hit = l2_hit;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_valid_r <= '0;
      l2_valid_r <= '0;
    end else begin
      if (l1_we) begin
        l1_valid_r[i1] <= 1'b1;
      end
      if (l2_we) begin
        l2_valid_r[i2] <= 1'b1;
      end
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_LOOKUP);
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_address;
    end
    if (state_r == ST_LOOKUP) begin
      if (l1_hit) begin
        out_latency_r   <= {1'b0, l1_lat_r};
        out_hit_level_r <= LVL_L1;
      end else begin
        out_latency_r   <= {1'b0, l1_lat_r} + {1'b0, l2_lat_r};
        out_hit_level_r <= l2_hit ? LVL_L2 : LVL_MISS;
      end
    end
  end

  // statistics
  tldc_stats u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt         (evt),
    .l1_hits     (out_first_level_hits),
    .l1_miss_cnt (out_first_level_misses),
    .l2_hits     (out_second_level_hits),
    .l2_miss_cnt (out_second_level_misses)
  );

  assign out_strobe    = out_strobe_r;
  assign out_latency   = out_latency_r;
  assign out_hit_level = out_hit_level_r;

  // the cycle after busy has busy low and a single result beat
  a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy && out_strobe)
    else $error("lookup did not finish in one cycle");

  a_strobe_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without a lookup");

  a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not start a lookup");

  // an l1 miss always leaves the line valid in l1
  a_l1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    l1_we |=> l1_valid_r[$past(i1)])
    else $error("l1 fill did not set the valid bit");

  // an l1 hit is charged the l1 latency only
  a_l1_hit_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_hit_level == LVL_L1) |-> out_latency == {1'b0, l1_lat_r})
    else $error("l1 hit latency mismatch");

endmodule
`default_nettype wire
